FILE: rtl/abba_baba_site_window_counter_assert.svh
// assertion macros for the abba baba site window counter
`ifndef ABBA_BABA_SITE_WINDOW_COUNTER_ASSERT_SVH
`define ABBA_BABA_SITE_WINDOW_COUNTER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define ABSWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define ABSWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/abswc_pkg.sv
// shared types, tables and constants for the abba baba site window counter
`default_nettype none

package abswc_pkg;

  localparam int NUM_LANES = 4;
  localparam int SIZE_BITS = 24;
  localparam int WIN_BITS = 20;
  localparam int DEF_COUNT_BITS = 24;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [SIZE_BITS-1:0] WINDOW_SIZE_RST = 24'd1000000;
  localparam logic [SIZE_BITS-1:0] STEP_SIZE_RST = 24'd100;

  // ambiguity codes for bytes 0x40 to 0x5f
  localparam logic [3:0] UPPER_CODES [32] = '{
    4'd15, 4'd1, 4'd14, 4'd2, 4'd13, 4'd15, 4'd15, 4'd4,
    4'd11, 4'd15, 4'd15, 4'd12, 4'd15, 4'd3, 4'd15, 4'd15,
    4'd15, 4'd15, 4'd5, 4'd6, 4'd8, 4'd15, 4'd7, 4'd9,
    4'd0, 4'd10, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15
  };

  // alleles per code, code zero counts as four
  localparam logic [2:0] ALLELE_TOTAL [16] = '{
    3'd4, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  typedef enum logic [1:0] {
    CFG_WINDOW_SIZE  = 2'd0,
    CFG_STEP_SIZE    = 2'd1,
    CFG_BINNING_MODE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REC_STEP   = 1'b0,
    REC_WINDOW = 1'b1
  } rec_kind_e;

  typedef struct packed {
    logic [SIZE_BITS-1:0] window_size;
    logic [SIZE_BITS-1:0] step_size;
    logic                 binning_mode;
  } cfg_t;

  typedef struct packed {
    logic [3:0] code;
    logic [3:0] pick;
    logic       bad;
  } lane_t;

  typedef struct packed {
    logic called;
    logic hom;
    logic het;
    logic abba;
    logic baba;
  } site_t;

endpackage

`default_nettype wire

FILE: rtl/abswc_lane.sv
// one lane: maps a base byte to its ambiguity code and picks one allele
`default_nettype none

module abswc_lane (
  input  logic [7:0]          base_i,
  input  logic                choice_i,
  output abswc_pkg::lane_t    lane_o
);
  import abswc_pkg::*;

  logic [3:0] code;
  logic [2:0] alleles;
  logic [3:0] low_bit;
  logic [3:0] high_bit;
  logic       lower_case;

  always_comb begin
    code = (base_i[7:5] == 3'b010) ? UPPER_CODES[base_i[4:0]] : 4'hF;
    alleles = ALLELE_TOTAL[code];
    low_bit = code & (~code + 4'd1);
    high_bit = code ^ low_bit;
    lower_case = (base_i >= 8'h61) && (base_i <= 8'h7A);
    lane_o.code = code;
    lane_o.bad = lower_case || (alleles > 3'd2);
    if (alleles == 3'd2) begin
      lane_o.pick = choice_i ? low_bit : high_bit;
    end else begin
      lane_o.pick = code;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/abswc_merge.sv
// merges the four lanes into the site class
`default_nettype none

module abswc_merge (
  input  abswc_pkg::lane_t lanes_i [abswc_pkg::NUM_LANES],
  output abswc_pkg::site_t site_o
);
  import abswc_pkg::*;

  logic [3:0] all_codes;
  logic       any_bad;
  logic       ok;
  logic       discordant;
  logic [3:0] p0, p1, p2, p3;

  always_comb begin
    all_codes = '0;
    any_bad = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      all_codes = all_codes | lanes_i[i].code;
      any_bad = any_bad | lanes_i[i].bad;
    end
    p0 = lanes_i[0].pick;
    p1 = lanes_i[1].pick;
    p2 = lanes_i[2].pick;
    p3 = lanes_i[3].pick;
    ok = !any_bad && (ALLELE_TOTAL[all_codes] <= 3'd2);
    discordant = (p0 != p1) && (p2 != p3);
    site_o.called = ok;
    site_o.hom = ok && (p0 == p1) && (p1 != p2) && (p2 == p3);
    site_o.het = ok && discordant;
    site_o.abba = ok && discordant && (p0 == p3);
    site_o.baba = ok && discordant && (p0 != p3);
  end

endmodule

`default_nettype wire

FILE: rtl/abswc_accum.sv
// step bin and window counters, builds the records that a site closes
`default_nettype none

module abswc_accum #(
  parameter int COUNT_BITS = abswc_pkg::DEF_COUNT_BITS,
  parameter int REC_W = 2 + abswc_pkg::WIN_BITS + 5 * COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic                  eos_i,
  input  abswc_pkg::site_t      site_i,
  input  abswc_pkg::cfg_t       cfg_i,
  output logic [REC_W-1:0]      rec0_o,
  output logic [REC_W-1:0]      rec1_o,
  output logic [1:0]            rec_cnt_o
);
  import abswc_pkg::*;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v,
                                                    input logic en);
    return (en && (v != '1)) ? v + COUNT_BITS'(1) : v;
  endfunction

  logic [SIZE_BITS-1:0]  step_sites_q, step_sites_d;
  logic [SIZE_BITS-1:0]  win_sites_q, win_sites_d;
  logic [COUNT_BITS-1:0] step_abba_q, step_abba_d;
  logic [COUNT_BITS-1:0] step_baba_q, step_baba_d;
  logic [COUNT_BITS-1:0] win_called_q, win_called_d;
  logic [COUNT_BITS-1:0] win_abba_q, win_abba_d;
  logic [COUNT_BITS-1:0] win_baba_q, win_baba_d;
  logic [COUNT_BITS-1:0] win_hom_q, win_hom_d;
  logic [COUNT_BITS-1:0] win_het_q, win_het_d;
  logic [WIN_BITS-1:0]   win_num_q, win_num_d;

  logic [SIZE_BITS-1:0]  step_inc, win_inc, step_lim, win_lim;
  logic                  step_close, win_close;
  logic [COUNT_BITS-1:0] s_abba, s_baba, w_called, w_abba, w_baba, w_hom, w_het;
  logic [COUNT_BITS-1:0] rec_abba, rec_baba;
  logic [REC_W-1:0]      step_rec, win_rec;

  always_comb begin
    step_inc = step_sites_q + SIZE_BITS'(1);
    win_inc = win_sites_q + SIZE_BITS'(1);
    step_lim = (cfg_i.step_size == '0) ? SIZE_BITS'(1) : cfg_i.step_size;
    win_lim = (cfg_i.window_size == '0) ? SIZE_BITS'(1) : cfg_i.window_size;
    step_close = eos_i || (step_inc >= step_lim);
    win_close = eos_i || (win_inc >= win_lim);

    s_abba = sat_inc(step_abba_q, site_i.abba);
    s_baba = sat_inc(step_baba_q, site_i.baba);
    w_called = sat_inc(win_called_q, site_i.called);
    w_abba = sat_inc(win_abba_q, site_i.abba);
    w_baba = sat_inc(win_baba_q, site_i.baba);
    w_hom = sat_inc(win_hom_q, site_i.hom);
    w_het = sat_inc(win_het_q, site_i.het);

    if (cfg_i.binning_mode) begin
      rec_abba = COUNT_BITS'(s_abba != '0);
      rec_baba = COUNT_BITS'(s_baba != '0);
    end else begin
      rec_abba = s_abba;
      rec_baba = s_baba;
    end

    step_rec = {REC_STEP, win_num_q, rec_abba, rec_baba,
                {COUNT_BITS{1'b0}}, {COUNT_BITS{1'b0}}, {COUNT_BITS{1'b0}}, !win_close};
    win_rec = {REC_WINDOW, win_num_q, w_abba, w_baba, w_called, w_hom, w_het, 1'b1};

    if (step_close) begin
      rec0_o = step_rec;
      rec1_o = win_rec;
    end else begin
      rec0_o = win_rec;
      rec1_o = win_rec;
    end
    rec_cnt_o = fire_i ? (2'(step_close) + 2'(win_close)) : 2'd0;
  end

  always_comb begin
    step_sites_d = step_sites_q;
    win_sites_d = win_sites_q;
    step_abba_d = step_abba_q;
    step_baba_d = step_baba_q;
    win_called_d = win_called_q;
    win_abba_d = win_abba_q;
    win_baba_d = win_baba_q;
    win_hom_d = win_hom_q;
    win_het_d = win_het_q;
    win_num_d = win_num_q;
    if (fire_i) begin
      if (step_close) begin
        step_sites_d = '0;
        step_abba_d = '0;
        step_baba_d = '0;
      end else begin
        step_sites_d = step_inc;
        step_abba_d = s_abba;
        step_baba_d = s_baba;
      end
      if (win_close) begin
        win_sites_d = '0;
        win_called_d = '0;
        win_abba_d = '0;
        win_baba_d = '0;
        win_hom_d = '0;
        win_het_d = '0;
        win_num_d = win_num_q + WIN_BITS'(1);
      end else begin
        win_sites_d = win_inc;
        win_called_d = w_called;
        win_abba_d = w_abba;
        win_baba_d = w_baba;
        win_hom_d = w_hom;
        win_het_d = w_het;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_sites_q <= '0;
      win_sites_q <= '0;
      step_abba_q <= '0;
      step_baba_q <= '0;
      win_called_q <= '0;
      win_abba_q <= '0;
      win_baba_q <= '0;
      win_hom_q <= '0;
      win_het_q <= '0;
      win_num_q <= '0;
    end else begin
      step_sites_q <= step_sites_d;
      win_sites_q <= win_sites_d;
      step_abba_q <= step_abba_d;
      step_baba_q <= step_baba_d;
      win_called_q <= win_called_d;
      win_abba_q <= win_abba_d;
      win_baba_q <= win_baba_d;
      win_hom_q <= win_hom_d;
      win_het_q <= win_het_d;
      win_num_q <= win_num_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/abswc_queue.sv
// small output queue that takes up to two records a cycle and gives one
`default_nettype none

module abswc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = abswc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  logic [WIDTH-1:0] push0_data_i,
  input  logic [WIDTH-1:0] push1_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             room2_o
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_next;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_next = wr_ptr_q + PTR_W'(1);
    wr_ptr_d = wr_ptr_q + PTR_W'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop_i);
    count_d = count_q + CNT_W'(push_cnt_i) - CNT_W'(pop_i);
    valid_o = (count_q != '0);
    data_o = mem_q[rd_ptr_q];
    room2_o = (count_q <= CNT_W'(DEPTH - 2));
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_data_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push1_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/abba_baba_site_window_counter.sv
// Counts ABBA/BABA site patterns over step bins and jackknife windows. One aligned
// site of four sequences is taken per cycle, back to back: four decode lanes map
// the bases to alleles, a merge stage classes the site, and the counters update in
// the cycle the request is taken, so its records can leave on the next cycle. A site
// emits zero, one or two records (step bin first, then window); records leave one per
// cycle through a 4-entry output queue and in_ready_o drops while fewer than two queue
// slots are free. Sites that close at most one record each run at full rate while the
// output is drained; a run of sites that close two records each is held to the output
// rate, and a stalled output blocks the input as soon as the queue holds more than
// two records.
// There is no clearing pass after reset; registers take effect from the next site.
`default_nettype none
`include "abba_baba_site_window_counter_assert.svh"

module abba_baba_site_window_counter #(
  parameter int COUNT_BITS = abswc_pkg::DEF_COUNT_BITS,
  parameter int QUEUE_DEPTH = abswc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [abswc_pkg::SIZE_BITS-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      base_u_i,
  input  logic [7:0]                      base_v_i,
  input  logic [7:0]                      base_x_i,
  input  logic [7:0]                      base_y_i,
  input  logic [3:0]                      allele_choice_i,
  input  logic                            end_of_sequence_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            record_kind_o,
  output logic [abswc_pkg::WIN_BITS-1:0]  window_number_o,
  output logic [COUNT_BITS-1:0]           abba_count_o,
  output logic [COUNT_BITS-1:0]           baba_count_o,
  output logic [COUNT_BITS-1:0]           called_count_o,
  output logic [COUNT_BITS-1:0]           hom_count_o,
  output logic [COUNT_BITS-1:0]           het_count_o,
  output logic                            last_o
);
  import abswc_pkg::*;

  localparam int REC_W = 2 + WIN_BITS + 5 * COUNT_BITS;

  cfg_t             cfg_q, cfg_d;
  lane_t            lanes [NUM_LANES];
  logic [7:0]       bases [NUM_LANES];
  site_t            site;
  logic             fire;
  logic             pop;
  logic             room2;
  logic [1:0]       push_cnt;
  logic [REC_W-1:0] rec0, rec1, head;
  logic             eos_fire;
  logic             head_more;
  logic             step_out;
  logic             head_zero;

  // configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_SIZE:  cfg_d.window_size = cfg_data_i;
        CFG_STEP_SIZE:    cfg_d.step_size = cfg_data_i;
        CFG_BINNING_MODE: cfg_d.binning_mode = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size <= WINDOW_SIZE_RST;
      cfg_q.step_size <= STEP_SIZE_RST;
      cfg_q.binning_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign bases[0] = base_u_i;
  assign bases[1] = base_v_i;
  assign bases[2] = base_x_i;
  assign bases[3] = base_y_i;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    abswc_lane u_lane (
      .base_i   (bases[g]),
      .choice_i (allele_choice_i[g]),
      .lane_o   (lanes[g])
    );
  end

  abswc_merge u_merge (
    .lanes_i (lanes),
    .site_o  (site)
  );

  assign in_ready_o = room2;
  assign fire = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  abswc_accum #(
    .COUNT_BITS (COUNT_BITS),
    .REC_W      (REC_W)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .eos_i     (end_of_sequence_i),
    .site_i    (site),
    .cfg_i     (cfg_q),
    .rec0_o    (rec0),
    .rec1_o    (rec1),
    .rec_cnt_o (push_cnt)
  );

  abswc_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cnt_i   (push_cnt),
    .push0_data_i (rec0),
    .push1_data_i (rec1),
    .pop_i        (pop),
    .valid_o      (out_valid_o),
    .data_o       (head),
    .room2_o      (room2)
  );

  assign {record_kind_o, window_number_o, abba_count_o, baba_count_o,
          called_count_o, hom_count_o, het_count_o, last_o} = head;

  // terms for the checks below
  assign eos_fire = fire && end_of_sequence_i;
  assign head_more = out_valid_o && !last_o;
  assign step_out = out_valid_o && (record_kind_o == REC_STEP);
  assign head_zero = (called_count_o == '0) && (hom_count_o == '0) && (het_count_o == '0);

  `ABSWC_ASSERT_NOW(a_eos_both, clk_i, rst_ni, eos_fire, push_cnt == 2'd2, "eos must close both")
  `ABSWC_ASSERT_NOW(a_step_not_last, clk_i, rst_ni, head_more, step_out, "window not last")
  `ABSWC_ASSERT_NOW(a_step_zero, clk_i, rst_ni, step_out, head_zero, "step carries window counts")

endmodule

`default_nettype wire

FILE: dv/abba_baba_site_window_counter_tb.sv
// testbench for the abba baba site window counter: directed and random sites, predicted records
module abba_baba_site_window_counter_tb;

  localparam int COUNT_BITS = abswc_pkg::DEF_COUNT_BITS;
  localparam int SIZE_BITS = abswc_pkg::SIZE_BITS;
  localparam int WIN_BITS = abswc_pkg::WIN_BITS;
  localparam logic [3:0] CODE_ANY = 4'hf;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_SITES = 40;

  typedef struct packed {
    logic [3:0][7:0] bases;
    logic [3:0]      choice;
    logic            eos;
  } site_req_t;

  typedef struct packed {
    abswc_pkg::rec_kind_e  kind;
    logic [WIN_BITS-1:0]   win;
    logic [COUNT_BITS-1:0] abba;
    logic [COUNT_BITS-1:0] baba;
    logic [COUNT_BITS-1:0] called;
    logic [COUNT_BITS-1:0] hom;
    logic [COUNT_BITS-1:0] het;
    logic                  last;
  } site_record_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = abswc_pkg::CFG_WINDOW_SIZE;
  logic [SIZE_BITS-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] base_u_i = '0;
  logic [7:0] base_v_i = '0;
  logic [7:0] base_x_i = '0;
  logic [7:0] base_y_i = '0;
  logic [3:0] allele_choice_i = '0;
  logic end_of_sequence_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic record_kind_o;
  logic [WIN_BITS-1:0] window_number_o;
  logic [COUNT_BITS-1:0] abba_count_o;
  logic [COUNT_BITS-1:0] baba_count_o;
  logic [COUNT_BITS-1:0] called_count_o;
  logic [COUNT_BITS-1:0] hom_count_o;
  logic [COUNT_BITS-1:0] het_count_o;
  logic last_o;

  abba_baba_site_window_counter u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .base_u_i          (base_u_i),
    .base_v_i          (base_v_i),
    .base_x_i          (base_x_i),
    .base_y_i          (base_y_i),
    .allele_choice_i   (allele_choice_i),
    .end_of_sequence_i (end_of_sequence_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .record_kind_o     (record_kind_o),
    .window_number_o   (window_number_o),
    .abba_count_o      (abba_count_o),
    .baba_count_o      (baba_count_o),
    .called_count_o    (called_count_o),
    .hom_count_o       (hom_count_o),
    .het_count_o       (het_count_o),
    .last_o            (last_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted block state
  logic [SIZE_BITS-1:0] cfg_window = abswc_pkg::WINDOW_SIZE_RST;
  logic [SIZE_BITS-1:0] cfg_step = abswc_pkg::STEP_SIZE_RST;
  logic cfg_binning = 1'b0;
  logic [SIZE_BITS-1:0] sites_step = '0;
  logic [SIZE_BITS-1:0] sites_window = '0;
  logic [COUNT_BITS-1:0] step_abba = '0;
  logic [COUNT_BITS-1:0] step_baba = '0;
  logic [COUNT_BITS-1:0] win_called = '0;
  logic [COUNT_BITS-1:0] win_abba = '0;
  logic [COUNT_BITS-1:0] win_baba = '0;
  logic [COUNT_BITS-1:0] win_hom = '0;
  logic [COUNT_BITS-1:0] win_het = '0;
  logic [WIN_BITS-1:0] window_index = '0;

  site_record_t pending_records [$];
  int fail_count = 0;
  int quiet_cycles = 0;
  int hold_asked = 0;
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;

  function automatic logic [3:0] base_code(logic [7:0] b);
    if (b >= 8'h40 && b < 8'h60) return abswc_pkg::UPPER_CODES[b[4:0]];
    return CODE_ANY;
  endfunction

  function automatic logic [7:0] letter_of(logic [3:0] code);
    int b;
    for (b = 8'h40; b < 8'h60; b++) begin
      if (base_code(b[7:0]) == code) return b[7:0];
    end
    return 8'h4e;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_up(logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return SIZE_BITS'($urandom_range(1, 12));
    if (r == 7) return '0;
    if (r == 8) return SIZE_MAX;
    return SIZE_BITS'($urandom_range(13, 1000));
  endfunction

  function automatic site_req_t site_of(logic [7:0] u, logic [7:0] v, logic [7:0] x,
                                        logic [7:0] y, logic [3:0] ch, logic eos);
    site_req_t s;
    s.bases[0] = u;
    s.bases[1] = v;
    s.bases[2] = x;
    s.bases[3] = y;
    s.choice = ch;
    s.eos = eos;
    return s;
  endfunction

  // two alleles across the four lanes, with the odd lowercase base
  function automatic site_req_t biallelic_site();
    site_req_t s;
    logic [3:0] a, b, code;
    int ia, lane, r;
    ia = $urandom_range(0, 3);
    a = 4'b0001 << ia;
    b = 4'b0001 << ((ia + $urandom_range(1, 3)) % 4);
    for (lane = 0; lane < 4; lane++) begin
      r = $urandom_range(0, 9);
      code = (r < 4) ? a : (r < 8) ? b : (a | b);
      s.bases[lane] = letter_of(code);
      if ($urandom_range(0, 29) == 0) s.bases[lane] = s.bases[lane] | 8'h20;
    end
    s.choice = 4'($urandom_range(0, 15));
    s.eos = ($urandom_range(0, 24) == 0);
    return s;
  endfunction

  function automatic site_req_t noise_site();
    site_req_t s;
    s.bases = $urandom;
    s.choice = 4'($urandom_range(0, 15));
    s.eos = ($urandom_range(0, 9) == 0);
    return s;
  endfunction

  // classify one site and queue the records it closes
  function automatic void tally_site(site_req_t s);
    logic [3:0] code [4];
    logic [3:0] pick [4];
    logic [3:0] lo, all;
    logic keep, have_step, have_win;
    logic [SIZE_BITS-1:0] step_lim, win_lim;
    site_record_t step_rec, win_rec;
    int i;
    keep = 1'b1;
    all = '0;
    for (i = 0; i < 4; i++) begin
      code[i] = base_code(s.bases[i]);
      pick[i] = code[i];
      if (s.bases[i] >= "a" && s.bases[i] <= "z") keep = 1'b0;
      if (abswc_pkg::ALLELE_TOTAL[code[i]] > 3'd2) begin
        keep = 1'b0;
      end else if (abswc_pkg::ALLELE_TOTAL[code[i]] == 3'd2) begin
        lo = code[i] & (~code[i] + 4'd1);
        pick[i] = s.choice[i] ? lo : (code[i] ^ lo);
      end
      all = all | code[i];
    end

    if (keep && abswc_pkg::ALLELE_TOTAL[all] <= 3'd2) begin
      win_called = sat_up(win_called);
      if (pick[0] == pick[1] && pick[1] != pick[2] && pick[2] == pick[3])
        win_hom = sat_up(win_hom);
      else if (pick[0] != pick[1] && pick[2] != pick[3])
        win_het = sat_up(win_het);
      if (pick[2] != pick[3] && pick[0] != pick[1]) begin
        if (pick[0] == pick[3]) begin
          win_abba = sat_up(win_abba);
          step_abba = sat_up(step_abba);
        end else begin
          win_baba = sat_up(win_baba);
          step_baba = sat_up(step_baba);
        end
      end
    end

    sites_step = sites_step + 1'b1;
    sites_window = sites_window + 1'b1;
    step_lim = (cfg_step == '0) ? SIZE_BITS'(1) : cfg_step;
    win_lim = (cfg_window == '0) ? SIZE_BITS'(1) : cfg_window;
    have_step = s.eos || sites_step >= step_lim;
    have_win = s.eos || sites_window >= win_lim;

    if (have_step) begin
      step_rec.kind = abswc_pkg::REC_STEP;
      step_rec.win = window_index;
      step_rec.abba = cfg_binning ? COUNT_BITS'(step_abba != 0) : step_abba;
      step_rec.baba = cfg_binning ? COUNT_BITS'(step_baba != 0) : step_baba;
      step_rec.called = '0;
      step_rec.hom = '0;
      step_rec.het = '0;
      step_rec.last = !have_win;
      pending_records.push_back(step_rec);
      sites_step = '0;
      step_abba = '0;
      step_baba = '0;
    end
    if (have_win) begin
      win_rec.kind = abswc_pkg::REC_WINDOW;
      win_rec.win = window_index;
      win_rec.abba = win_abba;
      win_rec.baba = win_baba;
      win_rec.called = win_called;
      win_rec.hom = win_hom;
      win_rec.het = win_het;
      win_rec.last = 1'b1;
      pending_records.push_back(win_rec);
      sites_window = '0;
      win_called = '0;
      win_abba = '0;
      win_baba = '0;
      win_hom = '0;
      win_het = '0;
      window_index = window_index + 1'b1;
    end
    if (s.eos) begin
      sites_step = '0;
      sites_window = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic send_site(input site_req_t s);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    base_u_i <= s.bases[0];
    base_v_i <= s.bases[1];
    base_x_i <= s.bases[2];
    base_y_i <= s.bases[3];
    allele_choice_i <= s.choice;
    end_of_sequence_i <= s.eos;
    do @(posedge clk_i); while (!in_ready_o);
    tally_site(s);
  endtask

  // stop offering and wait for every outstanding record
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input abswc_pkg::cfg_idx_e idx, input logic [SIZE_BITS-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      abswc_pkg::CFG_WINDOW_SIZE: cfg_window = val;
      abswc_pkg::CFG_STEP_SIZE: cfg_step = val;
      default: cfg_binning = val[0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_defaults_then_lowered();
    site_req_t s;
    int i;
    for (i = 0; i < 4; i++) begin
      s = biallelic_site();
      s.eos = 1'b0;
      send_site(s);
    end
    drain_and_settle();
    // both sizes now below the open counts
    write_reg(abswc_pkg::CFG_WINDOW_SIZE, 24'd3);
    write_reg(abswc_pkg::CFG_STEP_SIZE, 24'd2);
    send_site(site_of("A", "C", "C", "A", 4'h0, 1'b0));
    send_site(site_of("G", "G", "T", "T", 4'hf, 1'b0));
    drain_and_settle();
  endtask

  task automatic test_site_classes();
    write_reg(abswc_pkg::CFG_WINDOW_SIZE, 24'd7);
    write_reg(abswc_pkg::CFG_STEP_SIZE, 24'd3);
    write_reg(abswc_pkg::CFG_BINNING_MODE, 24'd0);
    send_site(site_of("A", "A", "A", "A", 4'h0, 1'b0));
    send_site(site_of("A", "A", "C", "C", 4'h0, 1'b0));
    send_site(site_of("A", "C", "C", "A", 4'h0, 1'b0));
    send_site(site_of("C", "A", "C", "A", 4'hf, 1'b0));
    send_site(site_of("M", "M", "M", "M", 4'b1001, 1'b0));
    send_site(site_of("M", "M", "M", "M", 4'b0101, 1'b0));
    send_site(site_of("a", "C", "C", "A", 4'h0, 1'b0));
    send_site(site_of("N", "A", "A", "A", 4'h0, 1'b0));
    send_site(site_of("X", "A", "A", "A", 4'h0, 1'b0));
    send_site(site_of("V", "A", "A", "A", 4'h0, 1'b0));
    send_site(site_of("A", "C", "G", "A", 4'h0, 1'b0));
    send_site(site_of(8'h00, 8'hff, 8'h7f, 8'h80, 4'hf, 1'b0));
    send_site(site_of("T", "G", "T", "G", 4'hf, 1'b0));
    send_site(site_of("A", "A", "G", "G", 4'h0, 1'b1));
    drain_and_settle();
  endtask

  task automatic test_binning_and_sizes();
    write_reg(abswc_pkg::CFG_BINNING_MODE, 24'd1);
    write_reg(abswc_pkg::CFG_STEP_SIZE, 24'd0);
    write_reg(abswc_pkg::CFG_WINDOW_SIZE, 24'd2);
    send_site(site_of("A", "C", "C", "A", 4'h0, 1'b0));
    send_site(site_of("A", "C", "C", "A", 4'h0, 1'b0));
    send_site(site_of("C", "A", "C", "A", 4'h0, 1'b0));
    drain_and_settle();
    write_reg(abswc_pkg::CFG_STEP_SIZE, SIZE_MAX);
    write_reg(abswc_pkg::CFG_WINDOW_SIZE, SIZE_MAX);
    send_site(site_of("C", "A", "C", "A", 4'h0, 1'b0));
    send_site(site_of("A", "C", "C", "A", 4'h0, 1'b1));
    drain_and_settle();
    // window fills exactly on the last site
    write_reg(abswc_pkg::CFG_BINNING_MODE, 24'd0);
    write_reg(abswc_pkg::CFG_STEP_SIZE, 24'd1);
    write_reg(abswc_pkg::CFG_WINDOW_SIZE, 24'd2);
    send_site(site_of("A", "A", "C", "C", 4'h0, 1'b0));
    send_site(site_of("A", "C", "C", "A", 4'h0, 1'b1));
    drain_and_settle();
  endtask

  task automatic test_backpressure();
    int i;
    write_reg(abswc_pkg::CFG_WINDOW_SIZE, 24'd1);
    write_reg(abswc_pkg::CFG_STEP_SIZE, 24'd1);
    write_reg(abswc_pkg::CFG_BINNING_MODE, SIZE_BITS'($urandom_range(0, 1)));
    tx_gaps = 1'b0;
    hold_asked++;
    for (i = 0; i < 20; i++) send_site(biallelic_site());
    tx_gaps = 1'b1;
    drain_and_settle();
  endtask

  task automatic test_random_streams();
    int phase, i;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(abswc_pkg::CFG_WINDOW_SIZE, pick_size());
      write_reg(abswc_pkg::CFG_STEP_SIZE, pick_size());
      write_reg(abswc_pkg::CFG_BINNING_MODE, SIZE_BITS'($urandom_range(0, 1)));
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      for (i = 0; i < PHASE_SITES; i++) begin
        if ($urandom_range(0, 99) < 85) send_site(biallelic_site());
        else send_site(noise_site());
      end
      drain_and_settle();
    end
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // output side: random stalls plus long hold-offs on request
  always @(posedge clk_i) begin : drive_out_ready
    int stall_left;
    int hold_left;
    int hold_seen;
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      stall_left = (rx_stalls && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      out_ready_i <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin : check_records
    site_record_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_records.size() == 0) begin
        report_mismatch("record with none outstanding", 32'(record_kind_o), 32'd0);
      end else begin
        want = pending_records.pop_front();
        if (record_kind_o !== want.kind)
          report_mismatch("record_kind", 32'(record_kind_o), 32'(want.kind));
        if (window_number_o !== want.win)
          report_mismatch("window_number", 32'(window_number_o), 32'(want.win));
        if (abba_count_o !== want.abba)
          report_mismatch("abba_count", 32'(abba_count_o), 32'(want.abba));
        if (baba_count_o !== want.baba)
          report_mismatch("baba_count", 32'(baba_count_o), 32'(want.baba));
        if (called_count_o !== want.called)
          report_mismatch("called_count", 32'(called_count_o), 32'(want.called));
        if (hom_count_o !== want.hom)
          report_mismatch("hom_count", 32'(hom_count_o), 32'(want.hom));
        if (het_count_o !== want.het)
          report_mismatch("het_count", 32'(het_count_o), 32'(want.het));
        if (last_o !== want.last) report_mismatch("last", 32'(last_o), 32'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d records outstanding", pending_records.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults_then_lowered();
    test_site_classes();
    test_binning_and_sizes();
    test_backpressure();
    test_random_streams();
    drain_and_settle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_records.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
